// ===== hdl/scs1a_pkg.sv =====
// ----------------------------------------------------------------------------
// scs1a_pkg
// Shared types, key codes and the key table for the set 1 scan code decoder.
// ----------------------------------------------------------------------------
package scs1a_pkg;

  localparam logic [7:0] PREFIX_EXT = 8'hE0;
  localparam logic [6:0] KEY_CTRL   = 7'h1D;
  localparam logic [6:0] KEY_LSHIFT = 7'h2A;
  localparam logic [6:0] KEY_RSHIFT = 7'h36;
  localparam logic [6:0] KEY_ALT    = 7'h38;
  localparam logic [6:0] KEY_CAPS   = 7'h3A;
  localparam logic [7:0] KEY_LAST   = 8'h3A;

  localparam int unsigned ROM_ADDR_W = 6;

  typedef struct packed {
    logic ext;
    logic shift;
    logic ctrl;
    logic alt;
    logic caps;
  } flags_t;

  typedef struct packed {
    logic [6:0] upper;
    logic [6:0] lower;
  } key_row_t;

  typedef struct packed {
    logic       valid;
    logic [6:0] ch;
    logic       ctrl;
    logic       alt;
  } result_t;

  function automatic key_row_t key_row(input logic [ROM_ADDR_W-1:0] idx);
    key_row_t r;
    case (idx)
      6'h01: r = '{7'h1B, 7'h1B};
      6'h02: r = '{7'h21, 7'h31};
      6'h03: r = '{7'h40, 7'h32};
      6'h04: r = '{7'h23, 7'h33};
      6'h05: r = '{7'h24, 7'h34};
      6'h06: r = '{7'h25, 7'h35};
      6'h07: r = '{7'h5E, 7'h36};
      6'h08: r = '{7'h26, 7'h37};
      6'h09: r = '{7'h2A, 7'h38};
      6'h0A: r = '{7'h28, 7'h39};
      6'h0B: r = '{7'h29, 7'h30};
      6'h0C: r = '{7'h5F, 7'h2D};
      6'h0D: r = '{7'h2B, 7'h3D};
      6'h0E: r = '{7'h08, 7'h08};
      6'h0F: r = '{7'h09, 7'h09};
      6'h10: r = '{7'h51, 7'h71};
      6'h11: r = '{7'h57, 7'h77};
      6'h12: r = '{7'h45, 7'h65};
      6'h13: r = '{7'h52, 7'h72};
      6'h14: r = '{7'h54, 7'h74};
      6'h15: r = '{7'h59, 7'h79};
      6'h16: r = '{7'h55, 7'h75};
      6'h17: r = '{7'h49, 7'h69};
      6'h18: r = '{7'h4F, 7'h6F};
      6'h19: r = '{7'h50, 7'h70};
      6'h1A: r = '{7'h7B, 7'h5B};
      6'h1B: r = '{7'h7D, 7'h5D};
      6'h1C: r = '{7'h0D, 7'h0D};
      6'h1E: r = '{7'h41, 7'h61};
      6'h1F: r = '{7'h53, 7'h73};
      6'h20: r = '{7'h44, 7'h64};
      6'h21: r = '{7'h46, 7'h66};
      6'h22: r = '{7'h47, 7'h67};
      6'h23: r = '{7'h48, 7'h68};
      6'h24: r = '{7'h4A, 7'h6A};
      6'h25: r = '{7'h4B, 7'h6B};
      6'h26: r = '{7'h4C, 7'h6C};
      6'h27: r = '{7'h3A, 7'h3B};
      6'h28: r = '{7'h22, 7'h27};
      6'h29: r = '{7'h7E, 7'h60};
      6'h2B: r = '{7'h7C, 7'h5C};
      6'h2C: r = '{7'h5A, 7'h7A};
      6'h2D: r = '{7'h58, 7'h78};
      6'h2E: r = '{7'h43, 7'h63};
      6'h2F: r = '{7'h56, 7'h76};
      6'h30: r = '{7'h42, 7'h62};
      6'h31: r = '{7'h4E, 7'h6E};
      6'h32: r = '{7'h4D, 7'h6D};
      6'h33: r = '{7'h3C, 7'h2C};
      6'h34: r = '{7'h3E, 7'h2E};
      6'h35: r = '{7'h3F, 7'h2F};
      6'h37: r = '{7'h2A, 7'h2A};
      6'h39: r = '{7'h20, 7'h20};
      default: r = '{7'h00, 7'h00};
    endcase
    return r;
  endfunction

  // digit and symbol keys: the upper column follows shift alone
  function automatic logic shift_only(input logic [6:0] code);
    return (code < 7'h0E) ||
           (code inside {7'h1A, 7'h1B, 7'h27, 7'h28, 7'h29, 7'h2B, 7'h33, 7'h34, 7'h35});
  endfunction

endpackage

// ===== hdl/scancode_set1_to_ascii.sv =====
// ----------------------------------------------------------------------------
// scancode_set1_to_ascii
// Translate set 1 keyboard scan bytes to ASCII with modifier tracking.
// ----------------------------------------------------------------------------
//  channel  dir  width  fields (lsb first)
//  s_*      in   8      scan_byte
//  m_*      out  16     ascii_char[6:0], ctrl_held, alt_held, zero pad
//
//  One byte per cycle sustained unless the output is held. The first stage
//  reads the key table and the flag memory; the second stage updates the flags,
//  writes them back and loads the output register.
//  Reset clears the flag memory valid bit, the pipe valid and the output valid.
//  A held output stalls a full update stage and the input in the same cycle;
//  an empty update stage still takes one more byte before the input stalls.
// ----------------------------------------------------------------------------
module scancode_set1_to_ascii (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // scan_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // ascii_char[6:0], ctrl_held[7], alt_held[8], 0
);
  import scs1a_pkg::*;

  logic       s_accept;
  logic       s1_valid;
  logic [7:0] s1_scan;
  logic       s1_adv;
  key_row_t   row;
  flags_t     cur;
  flags_t     nxt;
  result_t    res;
  result_t    out_q;

  assign s_accept = s_tvalid & s_tready;
  assign s1_adv   = s1_valid & (~m_tvalid | m_tready);
  assign s_tready = ~s1_valid | s1_adv;

  scs1a_key_rom u_rom (
    .clk     (clk),
    .rd_en   (s_accept),
    .rd_addr (s_tdata[ROM_ADDR_W-1:0]),
    .rd_data (row)
  );

  scs1a_flag_ram u_flags (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (s1_adv),
    .wr_data (nxt),
    .rd_data (cur)
  );

  scs1a_update u_upd (
    .scan (s1_scan),
    .cur  (cur),
    .row  (row),
    .nxt  (nxt),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_scan <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv && res.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res.valid) begin
      out_q <= res;
    end
  end

  assign m_tdata = {7'b0, out_q.alt, out_q.ctrl, out_q.ch};

endmodule

// ===== hdl/scs1a_key_rom.sv =====
// ----------------------------------------------------------------------------
// scs1a_key_rom
// Synchronous key table: both character columns of one row, from a registered read.
// ----------------------------------------------------------------------------
module scs1a_key_rom (
  input  logic                                 clk,
  input  logic                                 rd_en,
  input  logic [scs1a_pkg::ROM_ADDR_W-1:0]     rd_addr,
  output scs1a_pkg::key_row_t                  rd_data
);
  import scs1a_pkg::*;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= key_row(rd_addr);
    end
  end

endmodule

// ===== hdl/scs1a_flag_ram.sv =====
// ----------------------------------------------------------------------------
// scs1a_flag_ram
// One-entry modifier state memory with registered read and write-first bypass.
// ----------------------------------------------------------------------------
module scs1a_flag_ram (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  scs1a_pkg::flags_t   wr_data,
  output scs1a_pkg::flags_t   rd_data
);
  import scs1a_pkg::*;

  flags_t mem [1];
  logic   written;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[0] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= 1'b0;
      rd_data <= '0;
    end else begin
      if (wr_en) begin
        written <= 1'b1;
        rd_data <= wr_data;
      end else if (written) begin
        rd_data <= mem[0];
      end else begin
        rd_data <= '0;
      end
    end
  end

endmodule

// ===== hdl/scs1a_update.sv =====
// ----------------------------------------------------------------------------
// scs1a_update
// Decode one scan byte against the current flags: next flags and character.
// ----------------------------------------------------------------------------
module scs1a_update (
  input  logic [7:0]           scan,
  input  scs1a_pkg::flags_t    cur,
  input  scs1a_pkg::key_row_t  row,
  output scs1a_pkg::flags_t    nxt,
  output scs1a_pkg::result_t   res
);
  import scs1a_pkg::*;

  logic       make_ok;
  logic       col;
  logic [6:0] ch;

  always_comb begin
    nxt     = cur;
    res     = '0;
    make_ok = 1'b0;
    col     = 1'b0;
    ch      = '0;
    if (scan == PREFIX_EXT) begin
      nxt.ext = 1'b1;
    end else begin
      nxt.ext = 1'b0;
      if (scan[7]) begin
        if (scan[6:0] == KEY_CTRL) begin
          nxt.ctrl = 1'b0;
        end else if (!cur.ext && (scan[6:0] == KEY_LSHIFT || scan[6:0] == KEY_RSHIFT)) begin
          nxt.shift = 1'b0;
        end else if (scan[6:0] == KEY_ALT) begin
          nxt.alt = 1'b0;
        end
      end else begin
        if (cur.ext) begin
          make_ok = (scan[6:0] == KEY_ALT) || (scan[6:0] == KEY_CTRL);
        end else begin
          make_ok = (scan != 8'h00) && (scan <= KEY_LAST);
        end
        col = shift_only(scan[6:0]) ? cur.shift : (cur.shift ^ cur.caps);
        ch  = cur.ext ? 7'h00 : (col ? row.upper : row.lower);
        if (make_ok) begin
          if (ch != 7'h00) begin
            res = '{valid: 1'b1, ch: ch, ctrl: cur.ctrl, alt: cur.alt};
          end else begin
            case (scan[6:0])
              KEY_CTRL:   nxt.ctrl  = 1'b1;
              KEY_LSHIFT: nxt.shift = 1'b1;
              KEY_RSHIFT: nxt.shift = 1'b1;
              KEY_ALT:    nxt.alt   = 1'b1;
              KEY_CAPS:   nxt.caps  = ~cur.caps;
              default:    nxt.caps  = cur.caps;
            endcase
          end
        end
      end
    end
  end

endmodule

// ===== hdl/scs1a_checker.sv =====
// ----------------------------------------------------------------------------
// scs1a_checker
// Port-level checks on the scan code decoder, bound to the top level.
// ----------------------------------------------------------------------------
module scs1a_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);
  import scs1a_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output request changed while stalled");

  a_char_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[6:0] != 7'h00)
    else $error("zero character delivered");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[15:9] == 7'h00)
    else $error("output pad bits not zero");

  a_cause: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !$past(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("output request without a byte two cycles earlier");

  a_prefix_silent: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tdata == PREFIX_EXT |-> ##2 !$rose(m_tvalid))
    else $error("prefix byte produced a character");

endmodule

bind scancode_set1_to_ascii scs1a_checker u_scs1a_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== tb/key_char_checker.sv =====
// ----------------------------------------------------------------------------
// key_char_checker
// Watches the scan byte and character streams of the set 1 decoder, tracks
// the prefix and modifier flags on its own, predicts each character and
// compares it field by field with what the block sends.
// ----------------------------------------------------------------------------
module key_char_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // scan_byte
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // ascii_char[6:0], ctrl_held, alt_held, zero pad
  output int          mismatches,
  output int          chars_waiting
);

  timeunit 1ns;
  timeprecision 1ps;

  import scs1a_pkg::*;

  typedef struct packed {
    logic [6:0] ch;
    logic       ctrl;
    logic       alt;
  } key_char_t;

  bit [6:0] plain_col [59] = '{
    7'h00, 7'h1b, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2d, 7'h3d, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6f, 7'h70, 7'h5b, 7'h5d, 7'h0d, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6a, 7'h6b, 7'h6c, 7'h3b,
    7'h27, 7'h60, 7'h00, 7'h5c, 7'h7a, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6e,
    7'h6d, 7'h2c, 7'h2e, 7'h2f, 7'h00, 7'h2a, 7'h00, 7'h20, 7'h00
  };

  bit [6:0] shifted_col [59] = '{
    7'h00, 7'h1b, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5e, 7'h26, 7'h2a,
    7'h28, 7'h29, 7'h5f, 7'h2b, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
    7'h54, 7'h59, 7'h55, 7'h49, 7'h4f, 7'h50, 7'h7b, 7'h7d, 7'h0d, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4a, 7'h4b, 7'h4c, 7'h3a,
    7'h22, 7'h7e, 7'h00, 7'h7c, 7'h5a, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4e,
    7'h4d, 7'h3c, 7'h3e, 7'h3f, 7'h00, 7'h2a, 7'h00, 7'h20, 7'h00
  };

  key_char_t chars_due [$];
  key_char_t want;
  key_char_t got;

  logic prefix_seen;
  logic shift_dn;
  logic ctrl_dn;
  logic alt_dn;
  logic caps_lk;

  function automatic logic caps_ignored(input logic [7:0] code);
    if (code < 8'h0e) return 1'b1;
    case (code)
      8'h1a, 8'h1b, 8'h27, 8'h28, 8'h29, 8'h2b, 8'h33, 8'h34, 8'h35: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic decode_scan_byte(input logic [7:0] b);
    logic       was_ext;
    logic       upper;
    logic [6:0] key;
    logic [6:0] ch;
    was_ext = prefix_seen;
    key = b[6:0];
    if (b == PREFIX_EXT) begin
      prefix_seen = 1'b1;
      return;
    end
    prefix_seen = 1'b0;
    if (b[7]) begin
      if (key == KEY_CTRL) ctrl_dn = 1'b0;
      else if (!was_ext && (key == KEY_LSHIFT || key == KEY_RSHIFT)) shift_dn = 1'b0;
      else if (key == KEY_ALT) alt_dn = 1'b0;
      return;
    end
    if (was_ext) begin
      if (key == KEY_CTRL) ctrl_dn = 1'b1;
      else if (key == KEY_ALT) alt_dn = 1'b1;
      return;
    end
    if (b == 8'h00 || b > KEY_LAST) return;
    upper = caps_ignored(b) ? shift_dn : (shift_dn ^ caps_lk);
    ch = upper ? shifted_col[b[5:0]] : plain_col[b[5:0]];
    if (ch != 7'h00) begin
      chars_due.push_back('{ch: ch, ctrl: ctrl_dn, alt: alt_dn});
    end else if (key == KEY_CTRL) begin
      ctrl_dn = 1'b1;
    end else if (key == KEY_LSHIFT || key == KEY_RSHIFT) begin
      shift_dn = 1'b1;
    end else if (key == KEY_ALT) begin
      alt_dn = 1'b1;
    end else if (key == KEY_CAPS) begin
      caps_lk = ~caps_lk;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      chars_due.delete();
      mismatches = 0;
      prefix_seen = 1'b0;
      shift_dn = 1'b0;
      ctrl_dn = 1'b0;
      alt_dn = 1'b0;
      caps_lk = 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = '{ch: m_tdata[6:0], ctrl: m_tdata[7], alt: m_tdata[8]};
        if (chars_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected char: ascii %h ctrl %b alt %b",
                   $time, got.ch, got.ctrl, got.alt);
        end else begin
          want = chars_due.pop_front();
          if (got.ch !== want.ch) begin
            mismatches++;
            $display("%0t: ascii_char expected %h actual %h", $time, want.ch, got.ch);
          end
          if (got.ctrl !== want.ctrl) begin
            mismatches++;
            $display("%0t: ctrl_held expected %b actual %b", $time, want.ctrl, got.ctrl);
          end
          if (got.alt !== want.alt) begin
            mismatches++;
            $display("%0t: alt_held expected %b actual %b", $time, want.alt, got.alt);
          end
        end
      end
      if (s_tvalid && s_tready) decode_scan_byte(s_tdata);
    end
    chars_waiting = chars_due.size();
  end

endmodule

// ===== tb/tb_scancode_set1_to_ascii.sv =====
// ----------------------------------------------------------------------------
// tb_scancode_set1_to_ascii
// Feeds the set 1 decoder a directed run of key sequences and then random
// keystrokes, with random stalls on both streams; the checker predicts and
// compares every character and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_scancode_set1_to_ascii;

  timeunit 1ns;
  timeprecision 1ps;

  import scs1a_pkg::*;

  localparam int NUM_RANDOM = 1600;
  localparam int TAIL_START = 1400;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  int mismatches;
  int chars_waiting;
  int cycle_count;
  int bytes_sent;
  bit calm;
  bit tail_phase;

  logic [7:0] opening_seq [31] = '{
    8'h00, 8'h01, 8'h02, 8'h10,
    {1'b0, KEY_CAPS}, 8'h10, 8'h02,
    {1'b0, KEY_LSHIFT}, 8'h10, 8'h02, {1'b1, KEY_LSHIFT},
    {1'b0, KEY_CTRL}, PREFIX_EXT, {1'b0, KEY_ALT}, 8'h1e,
    PREFIX_EXT, PREFIX_EXT, {1'b1, KEY_CTRL}, PREFIX_EXT, {1'b1, KEY_ALT},
    8'h3b, 8'hff, 8'h80, PREFIX_EXT, 8'h10,
    {1'b0, KEY_RSHIFT}, PREFIX_EXT, {1'b1, KEY_LSHIFT}, 8'h1e,
    {1'b1, KEY_RSHIFT}, 8'h39
  };

  always #4 clk = ~clk;

  scancode_set1_to_ascii u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  key_char_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .mismatches    (mismatches),
    .chars_waiting (chars_waiting)
  );

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (!calm && !tail_phase && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 18);
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_keystroke();
    int pick;
    int mod_pick;
    logic [6:0] mods [4];
    pick = $urandom_range(0, 99);
    mod_pick = $urandom_range(0, 5);
    mods = '{KEY_CTRL, KEY_LSHIFT, KEY_RSHIFT, KEY_ALT};
    if (pick < 55) begin
      send_byte(8'($urandom_range(1, KEY_LAST)));
    end else if (pick < 65) begin
      if (mod_pick < 4) send_byte({1'b0, mods[mod_pick]});
      else if (mod_pick == 4) send_byte({1'b0, KEY_CAPS});
      else begin
        send_byte(PREFIX_EXT);
        send_byte({1'b0, ($urandom_range(0, 1) != 0) ? KEY_CTRL : KEY_ALT});
      end
    end else if (pick < 75) begin
      if (mod_pick < 4) send_byte({1'b1, mods[mod_pick]});
      else begin
        send_byte(PREFIX_EXT);
        send_byte({1'b1, (mod_pick == 4) ? KEY_CTRL : KEY_ALT});
      end
    end else if (pick < 83) begin
      send_byte({1'b1, 7'($urandom_range(0, 127))});
    end else if (pick < 91) begin
      send_byte(PREFIX_EXT);
      send_byte(8'($urandom_range(0, 255)));
    end else begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int hold;
    forever begin
      if (!calm && !tail_phase && $urandom_range(0, 4) == 0) begin
        hold = $urandom_range(1, 18);
        repeat (hold) begin
          @(negedge clk);
          m_tready <= 1'b0;
        end
      end else begin
        hold = $urandom_range(1, 40);
        repeat (hold) begin
          @(negedge clk);
          m_tready <= 1'b1;
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    bit paused;
    bytes_sent = 0;
    calm = 1'b0;
    tail_phase = 1'b0;
    paused = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (opening_seq[i]) send_byte(opening_seq[i]);

    bytes_sent = 0;
    while (bytes_sent < NUM_RANDOM) begin
      if (bytes_sent % 150 < 2) calm = ($urandom_range(0, 3) == 0);
      if (!paused && bytes_sent >= NUM_RANDOM / 2) begin
        paused = 1'b1;
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (chars_waiting == 0);
      end
      tail_phase = (bytes_sent >= TAIL_START);
      send_keystroke();
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (chars_waiting == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
